// File: hdl/ps2m_pkg.sv
// ----------------------------------------------------------------------------
// ps2m_pkg
// Shared types and constants for the PS/2 mouse packet event decoder.
// ----------------------------------------------------------------------------
package ps2m_pkg;

    // Controller status bits and packet layout
    localparam int unsigned ST_OUT_FULL_BIT = 0;
    localparam int unsigned ST_AUX_BIT      = 5;
    localparam int unsigned SYNC_BIT        = 3;
    localparam int unsigned PACKET_LEN      = 3;
    localparam int unsigned BTN_MAX         = 3;

    // Events per input byte and widths that follow from it
    localparam int unsigned EV_MAX   = 4;
    localparam int unsigned EV_CNT_W = 3;
    localparam int unsigned EV_IDX_W = 2;

    // Configuration register indexes
    localparam logic CFG_HANDLER_PRESENT = 1'b0;
    localparam logic CFG_EVENT_ENABLE    = 1'b1;

    // Event enable bits
    localparam int unsigned EN_MOVE    = 0;
    localparam int unsigned EN_PRESS   = 1;
    localparam int unsigned EN_RELEASE = 2;

    typedef enum logic [1:0] {
        EV_MOVE    = 2'd0,
        EV_PRESS   = 2'd1,
        EV_RELEASE = 2'd2
    } event_kind_t;

    typedef struct packed {
        event_kind_t        kind;
        logic signed [7:0]  delta_x;
        logic signed [8:0]  delta_y;
        logic [1:0]         button_number;
        logic               last_event;
    } event_t;

    typedef event_t [EV_MAX-1:0] event_list_t;

    typedef struct packed {
        logic       handler_present;
        logic [2:0] event_enable;
    } cfg_t;

endpackage

// File: hdl/ps2m_packet.sv
// ----------------------------------------------------------------------------
// ps2m_packet
// Packet assembly and event generation for one registered status/data pair.
// ----------------------------------------------------------------------------
module ps2m_packet #(
    parameter int unsigned BUTTON_COUNT = 3
) (
    input  logic               clk,
    input  logic               rst_n,
    input  ps2m_pkg::cfg_t     cfg,
    input  logic               take,
    input  logic [7:0]         status_byte,
    input  logic [7:0]         data_byte,
    output ps2m_pkg::event_list_t events,
    output logic [ps2m_pkg::EV_CNT_W-1:0] event_count
);
    import ps2m_pkg::*;

    localparam int unsigned NBTN = (BUTTON_COUNT > BTN_MAX) ? BTN_MAX : BUTTON_COUNT;

    logic [1:0] slot_reg;
    logic [1:0] slot_next;
    logic [7:0] bytes_reg [PACKET_LEN];
    logic [2:0] buttons_reg;
    logic [2:0] buttons_next;

    logic       byte_ok;
    logic [1:0] slot_eff;
    logic       packet_done;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [EV_MAX-1:0] cand_valid;
    event_t     cand [EV_MAX];

    assign byte_ok  = take && status_byte[ST_OUT_FULL_BIT] && status_byte[ST_AUX_BIT];
    assign slot_eff = (slot_reg == 2'd3) ? 2'd0 : slot_reg;

    // The completing byte always lands in the last slot
    assign b0 = bytes_reg[0];
    assign b1 = bytes_reg[1];
    assign b2 = data_byte;
    assign packet_done = byte_ok && cfg.handler_present
                         && (slot_eff == 2'(PACKET_LEN - 1)) && b0[SYNC_BIT];

    always_comb
    begin
        slot_next = slot_reg;
        if (byte_ok && cfg.handler_present)
        begin
            slot_next = (slot_eff == 2'(PACKET_LEN - 1)) ? 2'd0 : slot_eff + 2'd1;
        end
    end

    always_comb
    begin
        buttons_next = buttons_reg;
        if (packet_done)
        begin
            buttons_next = b0[2:0];
        end
    end

    // Candidate events: move first, then buttons in order
    always_comb
    begin
        cand_valid = '0;
        for (int i = 0; i < EV_MAX; i++)
        begin
            cand[i] = '0;
        end
        cand[0].kind    = EV_MOVE;
        cand[0].delta_x = b1;
        cand[0].delta_y = -$signed({b2[7], b2});
        cand_valid[0]   = packet_done && ((b1 != 8'd0) || (b2 != 8'd0))
                          && cfg.event_enable[EN_MOVE];
        for (int i = 0; i < BTN_MAX; i++)
        begin
            cand[i+1].kind          = b0[i] ? EV_PRESS : EV_RELEASE;
            cand[i+1].button_number = 2'(i + 1);
            if (i < NBTN)
            begin
                cand_valid[i+1] = packet_done && (b0[i] != buttons_reg[i])
                                  && (b0[i] ? cfg.event_enable[EN_PRESS]
                                            : cfg.event_enable[EN_RELEASE]);
            end
        end
    end

    // Pack valid candidates to the front; flag the final one
    always_comb
    begin
        logic [EV_CNT_W-1:0] n;
        logic                later;
        n = '0;
        events = '0;
        for (int i = 0; i < EV_MAX; i++)
        begin
            later = 1'b0;
            for (int j = i + 1; j < EV_MAX; j++)
            begin
                later = later | cand_valid[j];
            end
            if (cand_valid[i])
            begin
                events[n[EV_IDX_W-1:0]]            = cand[i];
                events[n[EV_IDX_W-1:0]].last_event = !later;
                n = n + EV_CNT_W'(1);
            end
        end
        event_count = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg    <= 2'd0;
            buttons_reg <= 3'd0;
        end
        else
        begin
            slot_reg    <= slot_next;
            buttons_reg <= buttons_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_ok)
        begin
            bytes_reg[slot_eff] <= data_byte;
        end
    end

endmodule

// File: hdl/ps2m_event_queue.sv
// ----------------------------------------------------------------------------
// ps2m_event_queue
// Event bank for one input byte, drained one event per cycle into an
// output register while the receiver takes its output.
// ----------------------------------------------------------------------------
module ps2m_event_queue (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  ps2m_pkg::event_list_t         events,
    input  logic [ps2m_pkg::EV_CNT_W-1:0] event_count,
    output logic                          bank_free,
    output ps2m_pkg::event_t              out_event,
    output logic                          out_valid,
    input  logic                          out_ready
);
    import ps2m_pkg::*;

    event_t                bank_reg [EV_MAX];
    logic [EV_CNT_W-1:0]   cnt_reg;
    logic [EV_CNT_W-1:0]   cnt_next;
    logic [EV_IDX_W-1:0]   idx_reg;
    logic [EV_IDX_W-1:0]   idx_next;
    logic                  valid_reg;
    logic                  valid_next;
    event_t                out_reg;
    logic                  pop;

    assign pop       = (cnt_reg != '0) && (!valid_reg || out_ready);
    assign bank_free = (cnt_reg == '0) || ((cnt_reg == EV_CNT_W'(1)) && pop);
    assign out_valid = valid_reg;
    assign out_event = out_reg;

    always_comb
    begin
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        if (load)
        begin
            cnt_next = event_count;
            idx_next = '0;
        end
        else if (pop)
        begin
            cnt_next = cnt_reg - EV_CNT_W'(1);
            idx_next = idx_reg + EV_IDX_W'(1);
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (pop)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int i = 0; i < EV_MAX; i++)
            begin
                bank_reg[i] <= events[i];
            end
        end
        if (pop)
        begin
            out_reg <= bank_reg[idx_reg];
        end
    end

endmodule

// File: hdl/ps2_mouse_packet_event_decoder_top.sv
// ----------------------------------------------------------------------------
// ps2_mouse_packet_event_decoder_top
// PS/2 mouse packet decoder: status/data byte stream in, input events out.
// ----------------------------------------------------------------------------
// Each input request carries a controller status byte and a data byte; only
// bytes with both output-full and auxiliary-data status bits set are used.
// They are gathered into three-byte mouse packets, and a packet whose first
// byte has its sync bit set yields a move event (when either delta is
// nonzero) followed by a press or release event per changed button, up to
// four events in all, each kind only if enabled and the final one marked by
// m_tlast. A packet without the sync bit is dropped and the packet slot is
// not resynchronized. With handler_present low, bytes overwrite the current
// slot and nothing is emitted. Timing: a request is decoded while it sits in
// the input register, its events load the event bank, and from there they
// move one by one into the output register. Bytes that give no event are
// taken one per cycle while the event bank is free; a packet-completing byte
// holds the event bank until its events have drained, one event per cycle
// while m_tready allows, and the next request waits for the bank. Write
// configuration only while the block is idle.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_event_decoder_top #(
    parameter int unsigned BUTTON_COUNT = 3
) (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write port
    input  logic        cfg_wen,
    input  logic        cfg_index,
    input  logic [2:0]  cfg_wdata,
    // Input stream; s_tdata: [7:0] status_byte, [15:8] data_byte
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,
    // Output stream; m_tdata: [1:0] event_kind, [9:2] delta_x,
    // [18:10] delta_y, [20:19] button_number, [23:21] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,
    output logic        m_tlast
);
    import ps2m_pkg::*;

    // Configuration registers
    logic       handler_present_reg;
    logic [2:0] event_enable_reg;
    cfg_t       cfg;

    // Input register
    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] status_reg;
    logic [7:0] data_reg;

    logic                decode_take;
    logic                bank_free;
    event_list_t         events;
    logic [EV_CNT_W-1:0] event_count;
    event_t              out_event;

    assign cfg.handler_present = handler_present_reg;
    assign cfg.event_enable    = event_enable_reg;

    // Decode the held request once the event bank can take its events
    assign decode_take = in_valid_reg && bank_free;
    assign s_tready    = !in_valid_reg || decode_take;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready)
        begin
            in_valid_next = 1'b1;
        end
        else if (decode_take)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            status_reg <= s_tdata[7:0];
            data_reg   <= s_tdata[15:8];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            handler_present_reg <= 1'b1;
            event_enable_reg    <= 3'd7;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                CFG_HANDLER_PRESENT: handler_present_reg <= cfg_wdata[0];
                CFG_EVENT_ENABLE:    event_enable_reg    <= cfg_wdata;
                default:             ;
            endcase
        end
    end

    ps2m_packet #(
        .BUTTON_COUNT (BUTTON_COUNT)
    ) u_packet (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .take        (decode_take),
        .status_byte (status_reg),
        .data_byte   (data_reg),
        .events      (events),
        .event_count (event_count)
    );

    ps2m_event_queue u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (decode_take),
        .events      (events),
        .event_count (event_count),
        .bank_free   (bank_free),
        .out_event   (out_event),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready)
    );

    assign m_tdata = {3'b000, out_event.button_number, out_event.delta_y,
                      out_event.delta_x, out_event.kind};
    assign m_tlast = out_event.last_event;

endmodule

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the PS/2 mouse packet event decoder.
// ----------------------------------------------------------------------------
// Streams status/data byte requests into the decoder and keeps a copy of its
// packet state in the bench. Each accepted byte is decoded into the list of
// move and button events it should raise; the list is queued in order. Every
// event the block hands out is checked field by field against the oldest
// queued one. A directed part covers delta extremes, every event kind, status
// filtering, a packet without the sync bit and the no-consumer mode. Random
// traffic then runs under several register settings and idle profiles.
// ----------------------------------------------------------------------------
module tb_top;

    import ps2m_pkg::*;

    localparam int unsigned BUTTON_COUNT  = 3;
    localparam int unsigned SETTLE_CYCLES = 10;
    localparam int unsigned MAX_REPORTS   = 10;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_wen   = 1'b0;
    logic        cfg_index = CFG_HANDLER_PRESENT;
    logic [2:0]  cfg_wdata = 3'd0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = 16'd0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tlast;

    // Idle odds in percent for each side of the stream
    int unsigned send_idle_pct = 19;
    int unsigned recv_idle_pct = 62;

    // Bench copy of the decoder's registers and packet state
    logic        cfg_handler = 1'b1;
    logic [2:0]  cfg_enable  = 3'd7;
    int unsigned pkt_slot    = 0;
    logic [7:0]  pkt_bytes [PACKET_LEN] = '{default: 8'd0};
    logic [2:0]  btn_state   = 3'd0;

    event_t      pending_events [$];
    int unsigned mismatch_count = 0;

    ps2_mouse_packet_event_decoder_top #(
        .BUTTON_COUNT (BUTTON_COUNT)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hard stop in case the block hangs or loses events
    initial
    begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Decode one accepted byte into the events it should raise, in order,
    // and advance the bench copy of the packet state.
    task automatic decode_mouse_byte(input logic [7:0] status, input logic [7:0] data);
        event_t      evs [$];
        event_t      ev;
        logic [8:0]  dy_ext;
        logic [2:0]  buttons;
        int unsigned nbtn;
        // Drop bytes that are not auxiliary data with output full
        if (!status[ST_AUX_BIT] || !status[ST_OUT_FULL_BIT])
            return;
        pkt_bytes[pkt_slot] = data;
        // Without a consumer the byte just overwrites the current slot
        if (!cfg_handler)
            return;
        pkt_slot = (pkt_slot == PACKET_LEN - 1) ? 0 : pkt_slot + 1;
        if (pkt_slot != 0)
            return;
        // Packet without sync: drop it, keep the buttons, no resync
        if (!pkt_bytes[0][SYNC_BIT])
            return;
        if ((pkt_bytes[1] != 8'd0 || pkt_bytes[2] != 8'd0) && cfg_enable[EN_MOVE])
        begin
            dy_ext           = {pkt_bytes[2][7], pkt_bytes[2]};
            ev.kind          = EV_MOVE;
            ev.delta_x       = pkt_bytes[1];
            ev.delta_y       = -dy_ext;
            ev.button_number = 2'd0;
            ev.last_event    = 1'b0;
            evs.push_back(ev);
        end
        buttons = pkt_bytes[0][2:0];
        nbtn    = (BUTTON_COUNT > BTN_MAX) ? BTN_MAX : BUTTON_COUNT;
        for (int i = 0; i < nbtn; i++)
        begin
            if (buttons[i] != btn_state[i])
            begin
                ev.delta_x       = 8'sd0;
                ev.delta_y       = 9'sd0;
                ev.button_number = 2'(i + 1);
                ev.last_event    = 1'b0;
                if (buttons[i] && cfg_enable[EN_PRESS])
                begin
                    ev.kind = EV_PRESS;
                    evs.push_back(ev);
                end
                else if (!buttons[i] && cfg_enable[EN_RELEASE])
                begin
                    ev.kind = EV_RELEASE;
                    evs.push_back(ev);
                end
            end
        end
        // Buttons update even when their events are masked off
        btn_state = buttons;
        foreach (evs[k])
        begin
            ev            = evs[k];
            ev.last_event = (k == evs.size() - 1);
            pending_events.push_back(ev);
        end
    endtask

    // Present one request, idling at random first, and hold it until taken.
    // Valid stays high on return so back-to-back requests need no drop.
    task automatic send_request(input logic [7:0] status, input logic [7:0] data);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tdata  = {data, status};
        s_tvalid = 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        decode_mouse_byte(status, data);
    endtask

    // Drop valid, wait for every queued event, then let the pipeline settle
    // with valid held low.
    task automatic wait_quiet();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [2:0] val);
        wait_quiet();
        @(negedge clk);
        cfg_wen   = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        if (idx == CFG_HANDLER_PRESENT)
            cfg_handler = val[0];
        else
            cfg_enable = val;
        @(negedge clk);
        cfg_wen = 1'b0;
    endtask

    // Receiver: stall at random, set at the falling edge
    always @(negedge clk)
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

    // Check every handed-out event against the oldest queued one
    always @(posedge clk)
    begin
        event_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_events.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected event: tdata=%h tlast=%b", m_tdata, m_tlast);
            end
            else
            begin
                want = pending_events.pop_front();
                if (m_tdata[1:0] !== want.kind || m_tdata[9:2] !== want.delta_x ||
                    m_tdata[18:10] !== want.delta_y ||
                    m_tdata[20:19] !== want.button_number || m_tlast !== want.last_event)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                    begin
                        $write("event mismatch: expected kind=%0d dx=%0d dy=%0d btn=%0d ",
                               want.kind, want.delta_x, want.delta_y, want.button_number);
                        $display("last=%b, got kind=%0d dx=%0d dy=%0d btn=%0d last=%b",
                                 want.last_event, m_tdata[1:0], $signed(m_tdata[9:2]),
                                 $signed(m_tdata[18:10]), m_tdata[20:19], m_tlast);
                    end
                end
            end
        end
    end

    // Full-scale deltas with every button pressed, then the opposite extremes
    // with every button released.
    task automatic test_motion_extremes();
        send_request(8'h21, 8'h0F);
        send_request(8'h21, 8'h7F);
        send_request(8'h21, 8'h80);
        send_request(8'h21, 8'h08);
        send_request(8'h21, 8'h80);
        send_request(8'h21, 8'h7F);
    endtask

    // Zero deltas give no move event, only the left press
    task automatic test_zero_motion();
        send_request(8'h21, 8'h09);
        send_request(8'h21, 8'h00);
        send_request(8'h21, 8'h00);
    endtask

    // Status bytes missing output-full or aux are dropped; an all-ones status
    // is taken.
    task automatic test_status_filter();
        send_request(8'h01, 8'hFF);
        send_request(8'h20, 8'hFF);
        send_request(8'h00, 8'hFF);
        send_request(8'hDE, 8'hFF);
        send_request(8'hFF, 8'h0A);
        send_request(8'h21, 8'h00);
        send_request(8'h21, 8'h01);
    endtask

    // Packet without sync: nothing raised, buttons held
    task automatic test_missing_sync();
        send_request(8'h21, 8'h07);
        send_request(8'h21, 8'h11);
        send_request(8'h21, 8'h22);
    endtask

    // No consumer: bytes overwrite slot 0 and nothing advances
    task automatic test_no_handler();
        write_reg(CFG_HANDLER_PRESENT, 3'd0);
        send_request(8'h21, 8'h33);
        send_request(8'h21, 8'h08);
        write_reg(CFG_HANDLER_PRESENT, 3'd1);
        send_request(8'h21, 8'h05);
        send_request(8'h21, 8'hFB);
    endtask

    // Random packets under one register setting. Most requests are accepted
    // bytes that follow the packet slot; a few carry a rejected status, and
    // some first bytes lack the sync bit.
    task automatic test_random_phase(input logic handler, input logic [2:0] enable,
                                     input int unsigned count);
        logic [7:0]  st;
        logic [7:0]  d;
        int unsigned taken;
        write_reg(CFG_HANDLER_PRESENT, {2'b00, handler});
        write_reg(CFG_EVENT_ENABLE, enable);
        taken = 0;
        while (taken < count)
        begin
            st = 8'($urandom);
            if ($urandom_range(0, 9) == 0)
            begin
                if ($urandom_range(0, 1) != 0)
                    st[ST_OUT_FULL_BIT] = 1'b0;
                else
                    st[ST_AUX_BIT] = 1'b0;
                send_request(st, 8'($urandom));
                continue;
            end
            st[ST_OUT_FULL_BIT] = 1'b1;
            st[ST_AUX_BIT]      = 1'b1;
            d = 8'($urandom);
            if (pkt_slot == 0)
                d[SYNC_BIT] = ($urandom_range(0, 99) < 85);
            else if ($urandom_range(0, 3) == 0)
                d = 8'd0;
            send_request(st, d);
            taken++;
        end
    endtask

    // Random traffic over three idle profiles, taking the registers through
    // their extremes along the way.
    task automatic test_random_traffic();
        send_idle_pct = 19;
        recv_idle_pct = 62;
        test_random_phase(1'b1, 3'd7, 48);
        test_random_phase(1'b1, 3'd1, 16);
        send_idle_pct = 62;
        recv_idle_pct = 19;
        test_random_phase(1'b1, 3'd6, 24);
        test_random_phase(1'b0, 3'd5, 8);
        test_random_phase(1'b1, 3'd2, 16);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_phase(1'b1, 3'd4, 16);
        test_random_phase(1'b1, 3'd0, 8);
        test_random_phase(1'b1, 3'd7, 40);
    endtask

    initial
    begin
        // Hold reset, then release it away from the active edge
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_motion_extremes();
        test_zero_motion();
        test_status_filter();
        test_missing_sync();
        test_no_handler();
        test_random_traffic();

        wait_quiet();
        if (mismatch_count == 0 && pending_events.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: filelist.f
hdl/ps2m_pkg.sv
hdl/ps2m_packet.sv
hdl/ps2m_event_queue.sv
hdl/ps2_mouse_packet_event_decoder_top.sv
test/tb_top.sv
